// ----- src/hydrostatic_pressure_test_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pressure test sequencer
// Wraps concurrent assertions so that they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef HYDROSTATIC_PRESSURE_TEST_SEQUENCER_TOP_ASSERT_SVH
`define HYDROSTATIC_PRESSURE_TEST_SEQUENCER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge, held off while reset is asserted.
`define HPTS_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hpts assertion failed");

// Checked at every rising edge, including during reset.
`define HPTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hpts assertion failed");

`else

`define HPTS_ASSERT_RST(lbl, clk, rst_n, prop)
`define HPTS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/hpts_pkg.sv -----
// ----------------------------------------------------------------------------
// Pressure test sequencer package
// Shared types, register indexes and codes of the pressure test sequencer.
// ----------------------------------------------------------------------------
package hpts_pkg;

  // Operation codes of an input request.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SECOND = 2'd1;
  localparam logic [1:0] OP_LOGIC  = 2'd2;
  localparam logic [1:0] OP_STOP   = 2'd3;

  // Inverter run commands.
  localparam logic [1:0] RUN_NONE  = 2'd0;
  localparam logic [1:0] RUN_START = 2'd1;
  localparam logic [1:0] RUN_STOP  = 2'd2;

  // Test phases.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PREP      = 3'd1;
  localparam logic [2:0] PH_RAMP_WORK = 3'd2;
  localparam logic [2:0] PH_HOLD_WORK = 3'd3;
  localparam logic [2:0] PH_RAMP_TEST = 3'd4;
  localparam logic [2:0] PH_HOLD_TEST = 3'd5;
  localparam logic [2:0] PH_PUMPDOWN  = 3'd6;
  localparam logic [2:0] PH_FINISH    = 3'd7;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKING_PRESSURE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_PRESSURE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKING_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_HOLD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_THRESH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PUMP_FREQUENCY   = 3'd6;

  // Logic ticks per reference step.
  localparam logic [3:0] SLOW_DIVIDE = 4'd10;

  typedef struct packed {
    logic [15:0] working_pressure;
    logic [15:0] test_pressure;
    logic [7:0]  working_hold_seconds;
    logic [7:0]  test_hold_seconds;
    logic [15:0] presence_threshold;
    logic [15:0] ramp_step;
    logic [15:0] pump_frequency;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pressure;
    logic        start_button;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        drive_valid;
    logic [15:0] drive_freq;
    logic [1:0]  run_cmd;
    logic        valve_open;
    logic        log_valid;
    logic [15:0] log_sample;
    logic        test_done;
    logic [15:0] reference_now;
    logic        is_running;
    logic [7:0]  hold_remaining;
  } out_item_t;

endpackage

// ----- src/hpts_if.sv -----
// ----------------------------------------------------------------------------
// Pressure test sequencer channels
// Valid/ready channels for sample requests and for sequencer results.
// ----------------------------------------------------------------------------
interface hpts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] pressure;
  logic        start_button;

  modport source (output valid, output op, output pressure, output start_button,
                  input ready);
  modport sink (input valid, input op, input pressure, input start_button,
                output ready);
endinterface

interface hpts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic        drive_valid;
  logic [15:0] drive_freq;
  logic [1:0]  run_cmd;
  logic        valve_open;
  logic        log_valid;
  logic [15:0] log_sample;
  logic        test_done;
  logic [15:0] reference_now;
  logic        is_running;
  logic [7:0]  hold_remaining;

  modport source (output valid, output phase, output drive_valid, output drive_freq,
                  output run_cmd, output valve_open, output log_valid,
                  output log_sample, output test_done, output reference_now,
                  output is_running, output hold_remaining, input ready);
  modport sink (input valid, input phase, input drive_valid, input drive_freq,
                input run_cmd, input valve_open, input log_valid,
                input log_sample, input test_done, input reference_now,
                input is_running, input hold_remaining, output ready);
endinterface

// ----- src/hpts_cfg.sv -----
// ----------------------------------------------------------------------------
// Pressure test sequencer configuration registers
// Holds the test targets, hold times, threshold, ramp step and pump frequency.
// ----------------------------------------------------------------------------
module hpts_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hpts_pkg::cfg_t                  cfg
);
  import hpts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORKING_PRESSURE: cfg_nxt.working_pressure = cfg_wdata;
        CFG_TEST_PRESSURE:    cfg_nxt.test_pressure = cfg_wdata;
        CFG_WORKING_HOLD:     cfg_nxt.working_hold_seconds = cfg_wdata[7:0];
        CFG_TEST_HOLD:        cfg_nxt.test_hold_seconds = cfg_wdata[7:0];
        CFG_PRESENCE_THRESH:  cfg_nxt.presence_threshold = cfg_wdata;
        CFG_RAMP_STEP:        cfg_nxt.ramp_step = cfg_wdata;
        CFG_PUMP_FREQUENCY:   cfg_nxt.pump_frequency = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.working_pressure     <= 16'd10000;
      cfg_r.test_pressure        <= 16'd15000;
      cfg_r.working_hold_seconds <= 8'd180;
      cfg_r.test_hold_seconds    <= 8'd120;
      cfg_r.presence_threshold   <= 16'd300;
      cfg_r.ramp_step            <= 16'd83;
      cfg_r.pump_frequency       <= 16'd5000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/hpts_core.sv -----
// ----------------------------------------------------------------------------
// Pressure test sequencer core
// Input register, phase and timer update logic, and the result register.
// ----------------------------------------------------------------------------
`include "hydrostatic_pressure_test_sequencer_top_assert.svh"

module hpts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  hpts_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  hpts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hpts_pkg::out_item_t out_data
);
  import hpts_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_d_r;
  logic      ov_r, ov_nxt;
  out_item_t od_r, res;

  logic [2:0]  ph_r, ph_nxt, ph_mid;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] ref_r, ref_nxt;
  logic        run_r, run_nxt;
  logic [3:0]  sd_r, sd_nxt, sd_inc;
  logic [16:0] ref_sum;

  logic can_out, s1_adv, in_acc;

  // The result register frees up when it is empty or being taken this cycle.
  assign can_out  = !ov_r || out_ready;
  assign s1_adv   = s1_v_r && can_out;
  assign in_ready = !s1_v_r || can_out;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (s1_adv) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign ref_sum = {1'b0, ref_r} + {1'b0, cfg.ramp_step};
  assign sd_inc  = sd_r + 4'd1;

  always_comb begin
    ph_nxt   = ph_r;
    ph_mid   = ph_r;
    hold_nxt = hold_r;
    ref_nxt  = ref_r;
    run_nxt  = run_r;
    sd_nxt   = sd_r;
    res      = '0;
    unique case (s1_d_r.op)
      OP_SAMPLE: begin
        unique case (ph_r)
          PH_IDLE: begin
            if (run_r) begin
              res.run_cmd = RUN_START;
              ph_mid = PH_PREP;
            end
          end
          PH_PREP: begin
            if (s1_d_r.pressure > cfg.presence_threshold) ph_mid = PH_RAMP_WORK;
          end
          PH_RAMP_WORK: begin
            if (s1_d_r.pressure >= cfg.working_pressure) begin
              ph_mid = PH_HOLD_WORK;
              hold_nxt = cfg.working_hold_seconds;
            end
            res.log_valid = 1'b1;
          end
          PH_HOLD_WORK: begin
            if (hold_r == 8'd0) ph_mid = PH_RAMP_TEST;
            res.log_valid = 1'b1;
          end
          PH_RAMP_TEST: begin
            if (s1_d_r.pressure > cfg.test_pressure) begin
              ph_mid = PH_HOLD_TEST;
              hold_nxt = cfg.test_hold_seconds;
            end
            res.log_valid = 1'b1;
          end
          PH_HOLD_TEST: begin
            if (hold_r == 8'd0) ph_mid = PH_PUMPDOWN;
            res.log_valid = 1'b1;
          end
          PH_PUMPDOWN: begin
            if (s1_d_r.pressure < cfg.presence_threshold) ph_mid = PH_FINISH;
            res.log_valid = 1'b1;
          end
          default: ;
        endcase
        if (res.log_valid) res.log_sample = s1_d_r.pressure;
        ph_nxt = ph_mid;

        // Drive decision is made on the phase just reached.
        unique case (ph_mid)
          PH_PREP: begin
            res.drive_valid = 1'b1;
            res.drive_freq  = cfg.pump_frequency;
          end
          PH_RAMP_WORK, PH_HOLD_WORK, PH_RAMP_TEST, PH_HOLD_TEST: begin
            res.drive_valid = 1'b1;
            res.drive_freq  = (s1_d_r.pressure < ref_r) ? cfg.pump_frequency : 16'd0;
          end
          PH_PUMPDOWN: begin
            res.valve_open = 1'b1;
            res.run_cmd    = RUN_STOP;
          end
          PH_FINISH: begin
            ph_nxt = PH_IDLE;
            run_nxt = 1'b0;
            res.test_done = 1'b1;
          end
          default: ;
        endcase
      end
      OP_SECOND: begin
        if (hold_r != 8'd0) hold_nxt = hold_r - 8'd1;
      end
      OP_LOGIC: begin
        sd_nxt = sd_inc;
        if (sd_inc == SLOW_DIVIDE) begin
          sd_nxt = 4'd0;
          if (!run_r) begin
            res.run_cmd = RUN_STOP;
            ph_nxt = PH_IDLE;
          end
          // A forced idle leaves the reference alone, so only a running test ramps.
          if (run_r && ph_r == PH_RAMP_WORK && ref_sum < {1'b0, cfg.working_pressure}) begin
            ref_nxt = ref_sum[15:0];
          end
          if (run_r && ph_r == PH_RAMP_TEST && ref_sum < {1'b0, cfg.test_pressure}) begin
            ref_nxt = ref_sum[15:0];
          end
        end
        run_nxt = s1_d_r.start_button;
      end
      OP_STOP: begin
        ph_nxt = PH_IDLE;
        hold_nxt = 8'd0;
        run_nxt = 1'b0;
      end
    endcase
    res.phase          = ph_nxt;
    res.reference_now  = ref_nxt;
    res.is_running     = run_nxt;
    res.hold_remaining = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
      ph_r   <= PH_IDLE;
      hold_r <= 8'd0;
      ref_r  <= 16'd0;
      run_r  <= 1'b0;
      sd_r   <= 4'd0;
    end else begin
      s1_v_r <= s1_v_nxt;
      ov_r   <= ov_nxt;
      if (s1_adv) begin
        ph_r   <= ph_nxt;
        hold_r <= hold_nxt;
        ref_r  <= ref_nxt;
        run_r  <= run_nxt;
        sd_r   <= sd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_d_r <= in_data;
    if (s1_adv) od_r <= res;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // The finish phase is left within the same request and is never stored.
  `HPTS_ASSERT_RST(a_no_stored_finish, clk, rst_n, ph_r != PH_FINISH)
  // Preparation is only entered from idle.
  `HPTS_ASSERT_RST(a_prep_from_idle, clk, rst_n,
    (ph_r == PH_PREP && $past(ph_r) != PH_PREP) |-> $past(ph_r) == PH_IDLE)
  // A request held in the input register is not dropped while the output stalls.
  `HPTS_ASSERT_RST(a_s1_held, clk, rst_n, (s1_v_r && !can_out) |=> s1_v_r)
  // The tick divider wraps before reaching its limit.
  `HPTS_ASSERT_RST(a_div_range, clk, rst_n, sd_r < SLOW_DIVIDE)

endmodule

// ----- src/hydrostatic_pressure_test_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Hydrostatic pressure test sequencer
// A request accepted into the input register has its result stored in the result register once the output can take it.
// Throughput: one request per cycle while the output channel takes each result; a stalled output holds the input.
// The input register and the result register part the two channels.
// Reset: synchronous, active low; clears phase, hold timer, reference, run flag,
// tick divider and both valid flags; configuration registers take defaults.
// ----------------------------------------------------------------------------
module hydrostatic_pressure_test_sequencer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  hpts_in_if.sink                         in_ch,
  hpts_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hpts_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data;
  out_item_t out_data;

  assign in_data.op           = in_ch.op;
  assign in_data.pressure     = in_ch.pressure;
  assign in_data.start_button = in_ch.start_button;

  hpts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hpts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.phase          = out_data.phase;
  assign out_ch.drive_valid    = out_data.drive_valid;
  assign out_ch.drive_freq     = out_data.drive_freq;
  assign out_ch.run_cmd        = out_data.run_cmd;
  assign out_ch.valve_open     = out_data.valve_open;
  assign out_ch.log_valid      = out_data.log_valid;
  assign out_ch.log_sample     = out_data.log_sample;
  assign out_ch.test_done      = out_data.test_done;
  assign out_ch.reference_now  = out_data.reference_now;
  assign out_ch.is_running     = out_data.is_running;
  assign out_ch.hold_remaining = out_data.hold_remaining;

endmodule
